// ===== hdl/soft_power_button_controller_macros.svh =====
// Assertion macros for the soft power button controller checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef SOFT_POWER_BUTTON_CONTROLLER_MACROS_SVH
`define SOFT_POWER_BUTTON_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SPBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spbc assertion failed");

// Next-cycle implication, checked out of reset.
`define SPBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spbc assertion failed");

`endif

// ===== hdl/spbc_pkg.sv =====
// Shared widths and codes for the soft power button controller.
// No dependencies.
package spbc_pkg;

  localparam int unsigned PressW  = 12;
  localparam int unsigned CountW  = 13;
  localparam int unsigned EmptyW  = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 16;

  typedef logic [PressW-1:0]  press_t;
  typedef logic [CountW-1:0]  count_t;
  typedef logic [EmptyW-1:0]  empty_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [CfgDatW-1:0] cfg_dat_t;
  typedef logic [2:0]         sound_t;
  typedef logic [1:0]         reason_t;

  // Register indexes
  localparam cfg_idx_t REG_SHORT_PRESS   = 8'd0;
  localparam cfg_idx_t REG_LONG_PRESS    = 8'd1;
  localparam cfg_idx_t REG_CALIB_CLEAR   = 8'd2;
  localparam cfg_idx_t REG_BATTERY_EMPTY = 8'd3;

  // Register reset values
  localparam press_t SHORT_PRESS_RST   = 12'd5;
  localparam press_t LONG_PRESS_RST    = 12'd300;
  localparam press_t CALIB_CLEAR_RST   = 12'd1000;
  localparam empty_t BATTERY_EMPTY_RST = 16'd500;

  // Sound codes
  localparam sound_t SOUND_NONE     = 3'd0;
  localparam sound_t SOUND_HAPPY    = 3'd1;
  localparam sound_t SOUND_SLEEPING = 3'd2;
  localparam sound_t SOUND_PUSHED   = 3'd3;
  localparam sound_t SOUND_SAD      = 3'd4;

  // Stop reasons
  localparam reason_t REASON_NONE        = 2'd0;
  localparam reason_t REASON_MANUAL      = 2'd1;
  localparam reason_t REASON_LOW_BATTERY = 2'd2;

  localparam empty_t EMPTY_MAX = 16'hFFFF;

endpackage

// ===== hdl/soft_power_button_controller.sv =====
// Soft power button controller: long-press power toggle, short-press stop,
// calibration clear and low-battery shutdown. Depends on spbc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one tick item: button level and
//   battery/drive status. Each accepted item produces exactly one result item
//   on the output channel (out_valid/out_ready).
//   Latency: the result of an item is valid the cycle after it is accepted.
//   Throughput: one item per cycle; all state updates are done by one pass of
//   compare/increment logic between the input ports and the result register.
//   in_ready stays high while the result register is empty or being drained,
//   so a new item is taken in the same cycle the previous result leaves.
//   Receiver stall: when out_valid is high and out_ready low, the result is
//   held and in_ready drops until it is taken; no item is lost.
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   indexes 0..3 write short press, long press, calibration clear and empty
//   battery thresholds, other indexes are dropped. Write only while idle.
//   Reset (rst_n low, synchronous): power off, all counters and flags clear,
//   thresholds back to 5/300/1000/500, result register empty.
module soft_power_button_controller (
  input  logic               clk,
  input  logic               rst_n,
  // tick items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_button_pressed,
  input  logic               in_battery_empty,
  input  logic               in_system_active,
  input  logic               in_ramp_finished,
  input  logic               in_speed_locked,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_power_enable,
  output spbc_pkg::sound_t   out_sound_code,
  output logic               out_stop_system,
  output spbc_pkg::reason_t  out_stop_reason,
  output logic               out_lights_off,
  output logic               out_clear_targets,
  output logic               out_lock_speed,
  output logic               out_calib_clear_active,
  output logic               out_shutdown_flag,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  spbc_pkg::cfg_idx_t cfg_index,
  input  spbc_pkg::cfg_dat_t cfg_data
);
  import spbc_pkg::*;

  // Threshold registers
  press_t short_ticks_r, long_ticks_r, calib_ticks_r;
  empty_t empty_ticks_r;

  // Tick state
  logic   is_on_r, is_on_nxt;
  count_t press_cnt_r, press_cnt_nxt;
  logic   toggle_r, toggle_nxt;
  logic   short_r, short_nxt;
  logic   calib_r, calib_nxt;
  logic   off_r, off_nxt;
  empty_t empty_cnt_r, empty_cnt_nxt;

  // Result register
  logic    out_valid_r;
  logic    pwr_r, stop_r, lights_r, clear_r, lock_r, calib_out_r, shut_r;
  sound_t  sound_r, sound_nxt;
  reason_t reason_r, reason_nxt;
  logic    stop_nxt, lights_nxt, clear_nxt, lock_nxt;

  logic   in_acc;
  count_t calib_ext, long_ext, short_ext;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  assign calib_ext = {1'b0, calib_ticks_r};
  assign long_ext  = {1'b0, long_ticks_r};
  assign short_ext = {1'b0, short_ticks_r};

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_ticks_r <= SHORT_PRESS_RST;
      long_ticks_r  <= LONG_PRESS_RST;
      calib_ticks_r <= CALIB_CLEAR_RST;
      empty_ticks_r <= BATTERY_EMPTY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SHORT_PRESS:   short_ticks_r <= cfg_data[PressW-1:0];
        REG_LONG_PRESS:    long_ticks_r  <= cfg_data[PressW-1:0];
        REG_CALIB_CLEAR:   calib_ticks_r <= cfg_data[PressW-1:0];
        REG_BATTERY_EMPTY: empty_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // One tick: button counter, then power machine, then low-battery check.
  always_comb begin
    press_cnt_nxt = press_cnt_r;
    toggle_nxt    = toggle_r;
    short_nxt     = short_r;
    calib_nxt     = calib_r;
    is_on_nxt     = is_on_r;
    off_nxt       = off_r;
    empty_cnt_nxt = empty_cnt_r;
    sound_nxt     = SOUND_NONE;
    reason_nxt    = REASON_NONE;
    stop_nxt      = 1'b0;
    lights_nxt    = 1'b0;
    clear_nxt     = 1'b0;
    lock_nxt      = 1'b0;

    // Held-press counter: count to the clear threshold, then step twice and rest.
    if (in_button_pressed) begin
      if (press_cnt_r < calib_ext) begin
        press_cnt_nxt = press_cnt_r + 1'b1;
      end else if (press_cnt_r == calib_ext) begin
        calib_nxt     = 1'b1;
        toggle_nxt    = 1'b0;
        press_cnt_nxt = calib_ext + 1'b1;
      end else if (press_cnt_r == calib_ext + 1'b1) begin
        press_cnt_nxt = calib_ext + 2'd2;
      end
      if (press_cnt_nxt == long_ext && !calib_nxt) begin
        toggle_nxt = 1'b1;
      end
    end else begin
      // Release between short and long thresholds latches a short press.
      if (press_cnt_r != '0 && press_cnt_r < long_ext && press_cnt_r >= short_ext) begin
        short_nxt = 1'b1;
      end
      press_cnt_nxt = '0;
      toggle_nxt    = 1'b0;
      calib_nxt     = 1'b0;
    end

    // Power machine; a short press latched while off waits for power on.
    if (!is_on_r) begin
      if (toggle_nxt) begin
        is_on_nxt  = 1'b1;
        toggle_nxt = 1'b0;
        off_nxt    = 1'b0;
        sound_nxt  = SOUND_HAPPY;
      end
    end else begin
      if (toggle_nxt) begin
        is_on_nxt  = 1'b0;
        toggle_nxt = 1'b0;
        off_nxt    = 1'b1;
        reason_nxt = REASON_MANUAL;
        stop_nxt   = 1'b1;
        sound_nxt  = SOUND_SLEEPING;
        lights_nxt = 1'b1;
      end
      if (short_nxt) begin
        short_nxt  = 1'b0;
        reason_nxt = REASON_MANUAL;
        stop_nxt   = 1'b1;
        sound_nxt  = SOUND_PUSHED;
        clear_nxt  = 1'b1;
      end
    end

    // Low battery: lock speed when balanced and ramped down, else count to forced off.
    if (is_on_nxt) begin
      if (in_battery_empty) begin
        if (in_system_active && in_ramp_finished) begin
          if (!in_speed_locked) begin
            sound_nxt = SOUND_SAD;
          end
          lock_nxt   = 1'b1;
          reason_nxt = REASON_LOW_BATTERY;
        end else begin
          if (empty_cnt_r != EMPTY_MAX) begin
            empty_cnt_nxt = empty_cnt_r + 1'b1;
          end
          if (empty_cnt_nxt >= empty_ticks_r) begin
            sound_nxt  = SOUND_SLEEPING;
            is_on_nxt  = 1'b0;
            toggle_nxt = 1'b0;
            off_nxt    = 1'b1;
            stop_nxt   = 1'b1;
          end
        end
      end else begin
        empty_cnt_nxt = '0;
      end
    end
  end

  // Advance state only on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_on_r     <= 1'b0;
      press_cnt_r <= '0;
      toggle_r    <= 1'b0;
      short_r     <= 1'b0;
      calib_r     <= 1'b0;
      off_r       <= 1'b0;
      empty_cnt_r <= '0;
    end else if (in_acc) begin
      is_on_r     <= is_on_nxt;
      press_cnt_r <= press_cnt_nxt;
      toggle_r    <= toggle_nxt;
      short_r     <= short_nxt;
      calib_r     <= calib_nxt;
      off_r       <= off_nxt;
      empty_cnt_r <= empty_cnt_nxt;
    end
  end

  // Result register: load on accept, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pwr_r       <= is_on_nxt;
      sound_r     <= sound_nxt;
      stop_r      <= stop_nxt;
      reason_r    <= reason_nxt;
      lights_r    <= lights_nxt;
      clear_r     <= clear_nxt;
      lock_r      <= lock_nxt;
      calib_out_r <= calib_nxt;
      shut_r      <= off_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_power_enable       = pwr_r;
  assign out_sound_code         = sound_r;
  assign out_stop_system        = stop_r;
  assign out_stop_reason        = reason_r;
  assign out_lights_off         = lights_r;
  assign out_clear_targets      = clear_r;
  assign out_lock_speed         = lock_r;
  assign out_calib_clear_active = calib_out_r;
  assign out_shutdown_flag      = shut_r;

endmodule

// ===== hdl/spbc_checker.sv =====
// Port-level checker for the soft power button controller, bound to the top.
// Depends on spbc_pkg and soft_power_button_controller_macros.svh.
`include "soft_power_button_controller_macros.svh"

module spbc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_power_enable,
  input spbc_pkg::sound_t   out_sound_code,
  input logic               out_stop_system,
  input spbc_pkg::reason_t  out_stop_reason,
  input logic               out_lights_off,
  input logic               out_clear_targets,
  input logic               out_lock_speed,
  input logic               out_shutdown_flag
);
  import spbc_pkg::*;

  // Stalled result holds.
  `SPBC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_sound_code) && $stable(out_stop_reason) && $stable(out_power_enable))
  // Speed lock always reports low battery.
  `SPBC_ASSERT_NOW(a_lock_reason, out_valid && out_lock_speed, out_stop_reason == REASON_LOW_BATTERY)
  // Lights off only on a manual power off.
  `SPBC_ASSERT_NOW(a_lights_off, out_valid && out_lights_off, out_stop_system && !out_power_enable && out_shutdown_flag)
  // Cleared targets come with a stop; a speed lock in the same tick may override the reason.
  `SPBC_ASSERT_NOW(a_clear_stop, out_valid && out_clear_targets, out_stop_system)
  // A happy sound leaves power on.
  `SPBC_ASSERT_NOW(a_happy_on, out_valid && out_sound_code == SOUND_HAPPY, out_power_enable && !out_shutdown_flag)

endmodule

bind soft_power_button_controller spbc_checker u_spbc_checker (.*);
